FILE: src/cta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_pkg: shared types and constants of the channel table
// Widths, operation/usage/outcome codes and the structs that travel between
// the controller and the row of table cells.
// ----------------------------------------------------------------------------
package cta_pkg;

  localparam int TABLE_ENTRIES = 16;

  localparam int OP_W   = 2;
  localparam int CHAN_W = 16;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 4;
  localparam int OUT_W  = 3;
  localparam int USE_W  = 2;
  localparam int AGE_W  = 16;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // slot numbers inside the block cover both the table depth and the 4-bit port
  localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_CONN = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK_RSV  = 2'd2;

  localparam logic [USE_W-1:0] USE_FREE      = 2'd0;
  localparam logic [USE_W-1:0] USE_RESERVED  = 2'd1;
  localparam logic [USE_W-1:0] USE_CONNECTED = 2'd2;

  localparam logic [OUT_W-1:0] OUT_FOUND    = 3'd0;
  localparam logic [OUT_W-1:0] OUT_FREE     = 3'd1;
  localparam logic [OUT_W-1:0] OUT_REPLACED = 3'd2;
  localparam logic [OUT_W-1:0] OUT_FULL     = 3'd3;
  localparam logic [OUT_W-1:0] OUT_MARKED   = 3'd4;
  localparam logic [OUT_W-1:0] OUT_IGNORED  = 3'd5;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef logic [CMP_W-1:0] slot_t;

  // request broadcast to every cell while a search wave runs
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] chan;
    logic [KIND_W-1:0] kind;
    slot_t             idx;
  } req_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    slot_t             hit_idx;
    logic [KIND_W-1:0] hit_kind;
    logic              free_ok;
    slot_t             free_idx;
    logic              old_ok;
    slot_t             old_idx;
    logic [AGE_W-1:0]  old_age;
    logic              mark_seen;
    logic              mark_used;
    logic [KIND_W-1:0] mark_kind;
  } rec_t;

  // allocation commit broadcast
  typedef struct packed {
    logic              en;
    slot_t             pick;
    logic [CHAN_W-1:0] chan;
    logic [KIND_W-1:0] kind;
  } cmt_t;

endpackage

FILE: src/cta_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_req_if: request channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface cta_req_if import cta_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAN_W-1:0] channel_number;
  logic [KIND_W-1:0] entry_kind;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, operation, channel_number, entry_kind, slot_index,
                  input ready);
  modport sink (input valid, operation, channel_number, entry_kind, slot_index,
                output ready);
endinterface

FILE: src/cta_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_rsp_if: response channel
// Valid/ready channel carrying one table result.
// ----------------------------------------------------------------------------
interface cta_rsp_if import cta_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] result_slot;
  logic [KIND_W-1:0] result_kind;
  logic [OUT_W-1:0]  outcome;

  modport source (output valid, result_slot, result_kind, outcome, input ready);
  modport sink (input valid, result_slot, result_kind, outcome, output ready);
endinterface

FILE: src/channel_table_age_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_table_age_replace: channel table with oldest-entry replacement
//
//   channel  | dir | transfer carries
//   req_i    | in  | operation, channel_number, entry_kind, slot_index
//   rsp_o    | out | result_slot, result_kind, outcome
//
// One request at a time. A search record walks the cell row one cell per
// cycle; the next request is taken once the result is loaded.
// Undefined operations are taken and dropped without a result.
// A stalled response holds the block in its final state until the transfer.
// Reset clears the whole table to free.
// ----------------------------------------------------------------------------
module channel_table_age_replace import cta_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cta_req_if.sink   req_i,
  cta_rsp_if.source rsp_o
);

  req_t req_w;
  cmt_t cmt_w;
  rec_t rec_w [TABLE_ENTRIES+1];

  cta_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .req_o    (req_w),
    .launch_o (rec_w[0]),
    .last_i   (rec_w[TABLE_ENTRIES]),
    .cmt_o    (cmt_w)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cta_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CMP_W'(i)),
      .req_i     (req_w),
      .cmt_i     (cmt_w),
      .rec_i     (rec_w[i]),
      .rec_o     (rec_w[i+1])
    );
  end

endmodule

FILE: src/cta_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_cell: one table entry
// Holds usage, channel, kind and age of one slot. Folds its entry into the
// passing search record, applies marks on the way, and takes allocation
// commits and age updates from the broadcast.
// ----------------------------------------------------------------------------
module cta_cell import cta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  slot_t cell_id_i,
  input  req_t  req_i,
  input  cmt_t  cmt_i,
  input  rec_t  rec_i,
  output rec_t  rec_o
);

  logic [USE_W-1:0]  use_q, use_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [AGE_W-1:0]  age_q, age_d;
  rec_t              rec_q, rec_d;

  logic is_mark;

  assign is_mark = (req_i.op == OP_MARK_CONN) || (req_i.op == OP_MARK_RSV);

  always_comb begin
    rec_d  = rec_i;
    use_d  = use_q;
    chan_d = chan_q;
    kind_d = kind_q;
    age_d  = age_q;

    if (rec_i.valid) begin
      if (req_i.op == OP_LOOKUP && !rec_i.hit) begin
        if (use_q == USE_FREE) begin
          if (!rec_i.free_ok) begin
            rec_d.free_ok  = 1'b1;
            rec_d.free_idx = cell_id_i;
          end
        end else if (chan_q == req_i.chan) begin
          rec_d.hit      = 1'b1;
          rec_d.hit_idx  = cell_id_i;
          rec_d.hit_kind = kind_q;
        end else if (use_q == USE_RESERVED &&
                     (!rec_i.old_ok || rec_i.old_age < age_q)) begin
          // strict compare keeps the lowest index on equal ages
          rec_d.old_ok  = 1'b1;
          rec_d.old_idx = cell_id_i;
          rec_d.old_age = age_q;
        end
      end
      if (is_mark && cell_id_i == req_i.idx) begin
        rec_d.mark_seen = 1'b1;
        rec_d.mark_used = (use_q != USE_FREE);
        rec_d.mark_kind = kind_q;
        if (use_q != USE_FREE) begin
          use_d = (req_i.op == OP_MARK_CONN) ? USE_CONNECTED : USE_RESERVED;
        end
      end
    end

    if (cmt_i.en) begin
      if (use_q == USE_RESERVED && age_q != AGE_MAX) begin
        age_d = age_q + AGE_W'(1);
      end
      if (cmt_i.pick == cell_id_i) begin
        use_d  = USE_RESERVED;
        chan_d = cmt_i.chan;
        kind_d = cmt_i.kind;
        age_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q  <= USE_FREE;
      chan_q <= '0;
      kind_q <= '0;
      age_q  <= '0;
      rec_q  <= '0;
    end else begin
      use_q  <= use_d;
      chan_q <= chan_d;
      kind_q <= kind_d;
      age_q  <= age_d;
      rec_q  <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

FILE: src/cta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_ctrl: request sequencer
// Takes a request, launches a search record into the cell row, decodes the
// record that leaves the last cell, drives the allocation commit and holds
// the result register.
// ----------------------------------------------------------------------------
module cta_ctrl import cta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cta_req_if.sink   req_i,
  cta_rsp_if.source rsp_o,
  output req_t  req_o,
  output rec_t  launch_o,
  input  rec_t  last_i,
  output cmt_t  cmt_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  req_t       req_q, req_d;
  logic       launch_q, launch_d;

  logic [SLOT_W-1:0] fin_slot_q, fin_slot_d;
  logic [KIND_W-1:0] fin_kind_q, fin_kind_d;
  logic [OUT_W-1:0]  fin_out_q, fin_out_d;
  logic              fin_alloc_q, fin_alloc_d;
  slot_t             fin_pick_q, fin_pick_d;

  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;
  logic [OUT_W-1:0]  out_code_q, out_code_d;

  logic accept, known_op, out_free, deliver;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign known_op    = (req_i.operation == OP_LOOKUP) ||
                       (req_i.operation == OP_MARK_CONN) ||
                       (req_i.operation == OP_MARK_RSV);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign deliver     = (state_q == S_DONE) && out_free;

  // decode of the record leaving the last cell
  always_comb begin
    fin_slot_d  = fin_slot_q;
    fin_kind_d  = fin_kind_q;
    fin_out_d   = fin_out_q;
    fin_alloc_d = fin_alloc_q;
    fin_pick_d  = fin_pick_q;
    if (last_i.valid) begin
      fin_alloc_d = 1'b0;
      fin_pick_d  = '0;
      case (req_q.op)
        OP_LOOKUP: begin
          if (last_i.hit) begin
            fin_slot_d = last_i.hit_idx[SLOT_W-1:0];
            fin_kind_d = last_i.hit_kind;
            fin_out_d  = OUT_FOUND;
          end else if (last_i.free_ok) begin
            fin_alloc_d = 1'b1;
            fin_pick_d  = last_i.free_idx;
            fin_slot_d  = last_i.free_idx[SLOT_W-1:0];
            fin_kind_d  = req_q.kind;
            fin_out_d   = OUT_FREE;
          end else if (last_i.old_ok) begin
            fin_alloc_d = 1'b1;
            fin_pick_d  = last_i.old_idx;
            fin_slot_d  = last_i.old_idx[SLOT_W-1:0];
            fin_kind_d  = req_q.kind;
            fin_out_d   = OUT_REPLACED;
          end else begin
            fin_slot_d = '0;
            fin_kind_d = '0;
            fin_out_d  = OUT_FULL;
          end
        end
        OP_MARK_CONN, OP_MARK_RSV: begin
          fin_slot_d = req_q.idx[SLOT_W-1:0];
          fin_kind_d = last_i.mark_seen ? last_i.mark_kind : '0;
          fin_out_d  = (last_i.mark_seen && last_i.mark_used) ? OUT_MARKED : OUT_IGNORED;
        end
        default: begin
          fin_out_d = OUT_IGNORED;
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    launch_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d.op   = req_i.operation;
          req_d.chan = req_i.channel_number;
          req_d.kind = req_i.entry_kind;
          req_d.idx  = CMP_W'(req_i.slot_index);
          if (known_op) begin
            launch_d = 1'b1;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (last_i.valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_kind_d  = out_kind_q;
    out_code_d  = out_code_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (deliver) begin
      out_valid_d = 1'b1;
      out_slot_d  = fin_slot_q;
      out_kind_d  = fin_kind_q;
      out_code_d  = fin_out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fin_alloc_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
      fin_alloc_q <= fin_alloc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    fin_slot_q <= fin_slot_d;
    fin_kind_q <= fin_kind_d;
    fin_out_q  <= fin_out_d;
    fin_pick_q <= fin_pick_d;
    out_slot_q <= out_slot_d;
    out_kind_q <= out_kind_d;
    out_code_q <= out_code_d;
  end

  always_comb begin
    launch_o       = '0;
    launch_o.valid = launch_q;
  end

  assign req_o = req_q;

  assign cmt_o.en   = deliver && fin_alloc_q;
  assign cmt_o.pick = fin_pick_q;
  assign cmt_o.chan = req_q.chan;
  assign cmt_o.kind = req_q.kind;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_slot = out_slot_q;
  assign rsp_o.result_kind = out_kind_q;
  assign rsp_o.outcome     = out_code_q;

`ifndef SYNTH
  // a record only leaves the row while a search is running
  a_rec_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_i.valid |-> state_q == S_SCAN)
    else $error("search record outside scan");

  // a search is launched only right after a request transfer
  a_launch_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> state_q == S_SCAN && $past(accept))
    else $error("launch without request");

  // commits target an existing slot and happen only with a result loaded
  a_commit_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt_o.en |-> int'(cmt_o.pick) < TABLE_ENTRIES && deliver)
    else $error("bad commit");

  // every delivered result shows up on the response channel next cycle
  a_deliver_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deliver |=> rsp_o.valid)
    else $error("result lost");
`endif

endmodule

FILE: tb/sv/channel_table_age_replace_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_table_age_replace_tb: self-checking bench for the channel table
// Drives lookups and slot marks through the request channel and checks every
// response against a behavioral copy of the table (usage, channel, kind and
// age per slot). A short directed table is followed by random episodes: mixed
// traffic, fill-and-connect runs that drive the table full, miss-heavy runs
// and noise. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module channel_table_age_replace_tb;
  import cta_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int ITEM_TARGET    = 1250;
  localparam int QUIET_ITEMS    = 150;
  // worst quiet stretch: a search, a response stall and a request gap;
  // taken several times over
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 2 * (TABLE_ENTRIES + 3) + 20;
  localparam int POOL_SIZE      = 24;

  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] chan;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] idx;
  } table_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic [OUT_W-1:0]  outcome;
  } table_rsp_t;

  typedef struct {
    table_req_t req;
    bit         typed;
    table_rsp_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cta_req_if req_if ();
  cta_rsp_if rsp_if ();

  channel_table_age_replace dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // behavioral copy of the table
  logic [USE_W-1:0]  table_use  [TABLE_ENTRIES];
  logic [CHAN_W-1:0] table_chan [TABLE_ENTRIES];
  logic [KIND_W-1:0] table_kind [TABLE_ENTRIES];
  logic [AGE_W-1:0]  table_age  [TABLE_ENTRIES];

  table_rsp_t        pending_results[$];
  dir_row_t          dir_rows[$];
  logic [CHAN_W-1:0] chan_pool [POOL_SIZE];

  int fail_cnt;
  int requests_sent;
  bit src_idle_en;
  bit sink_idle_en;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic table_req_t make_req(input logic [OP_W-1:0] op,
                                          input logic [CHAN_W-1:0] chan,
                                          input logic [KIND_W-1:0] kind,
                                          input logic [SLOT_W-1:0] idx);
    table_req_t r;
    r.op   = op;
    r.chan = chan;
    r.kind = kind;
    r.idx  = idx;
    return r;
  endfunction

  // applies one request to the table copy; returns 0 when no result follows
  function automatic bit predict_table_op(input table_req_t r, output table_rsp_t e);
    int free_at;
    int old_at;
    int pick;
    e       = '0;
    free_at = -1;
    old_at  = -1;
    if (r.op == OP_LOOKUP) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (table_use[i] == USE_FREE) begin
          if (free_at < 0) free_at = i;
        end else begin
          if (table_chan[i] == r.chan) begin
            e.slot    = SLOT_W'(i);
            e.kind    = table_kind[i];
            e.outcome = OUT_FOUND;
            return 1'b1;
          end
          // oldest is judged on ages before this miss bumps them
          if (table_use[i] == USE_RESERVED &&
              (old_at < 0 || table_age[old_at] < table_age[i])) old_at = i;
        end
      end
      if (free_at < 0 && old_at < 0) begin
        e.outcome = OUT_FULL;
        return 1'b1;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (table_use[i] == USE_RESERVED && table_age[i] != AGE_MAX)
          table_age[i] = table_age[i] + 1'b1;
      end
      pick      = (free_at >= 0) ? free_at : old_at;
      e.outcome = (free_at >= 0) ? OUT_FREE : OUT_REPLACED;
      table_use[pick]  = USE_RESERVED;
      table_chan[pick] = r.chan;
      table_kind[pick] = r.kind;
      table_age[pick]  = '0;
      e.slot = SLOT_W'(pick);
      e.kind = r.kind;
      return 1'b1;
    end
    if (r.op == OP_MARK_CONN || r.op == OP_MARK_RSV) begin
      e.slot = r.idx;
      if (int'(r.idx) >= TABLE_ENTRIES) begin
        e.outcome = OUT_IGNORED;
        return 1'b1;
      end
      e.kind = table_kind[r.idx];
      if (table_use[r.idx] == USE_FREE) begin
        e.outcome = OUT_IGNORED;
        return 1'b1;
      end
      table_use[r.idx] = (r.op == OP_MARK_CONN) ? USE_CONNECTED : USE_RESERVED;
      e.outcome = OUT_MARKED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] chan,
                         input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] idx,
                         input bit typed, input logic [SLOT_W-1:0] slot,
                         input logic [KIND_W-1:0] rkind, input logic [OUT_W-1:0] outcome);
    dir_row_t row;
    row.req          = make_req(op, chan, kind, idx);
    row.typed        = typed;
    row.want.slot    = slot;
    row.want.kind    = rkind;
    row.want.outcome = outcome;
    dir_rows.push_back(row);
  endtask

  // one request transfer; valid stays high afterwards unless the next call idles
  task automatic drive_request(input table_req_t r, input bit typed,
                               input table_rsp_t typed_want);
    int         gap;
    bit         has_result;
    table_rsp_t want;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= r.op;
    req_if.channel_number <= r.chan;
    req_if.entry_kind     <= r.kind;
    req_if.slot_index     <= r.idx;
    do @(posedge clk_i); while (!req_if.ready);
    has_result = predict_table_op(r, want);
    if (typed) want = typed_want;
    if (has_result) pending_results.push_back(want);
    if (r.op != OP_UNDEF) requests_sent++;
  endtask

  task automatic send(input table_req_t r);
    drive_request(r, 1'b0, '0);
  endtask

  function automatic logic [KIND_W-1:0] rand_kind();
    return KIND_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [CHAN_W-1:0] pool_chan();
    return chan_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // response side: check each transfer, then decide ready for the next edge
  always @(posedge clk_i) begin : rsp_side
    table_rsp_t want;
    int         stall_left;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: slot %0d kind %0d outcome %0d",
               rsp_if.result_slot, rsp_if.result_kind, rsp_if.outcome);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.result_slot !== want.slot) begin
          $error("result_slot: expected %0d, actual %0d", want.slot, rsp_if.result_slot);
          fail_cnt++;
        end
        if (rsp_if.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, rsp_if.result_kind);
          fail_cnt++;
        end
        if (rsp_if.outcome !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, rsp_if.outcome);
          fail_cnt++;
        end
      end
    end
    if (!rst_ni) begin
      stall_left = 0;
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    wait (rst_ni === 1'b1);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stuck = 0;
      else stuck++;
    end
    $display("channel_table_age_replace_tb failed");
    $finish;
  end

  initial begin : stimulus
    int  episode;
    int  n;
    int  p_conn;
    int  off;
    bit  first;
    dir_row_t row;

    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.operation      <= OP_LOOKUP;
    req_if.channel_number <= '0;
    req_if.entry_kind     <= '0;
    req_if.slot_index     <= '0;
    fail_cnt      = 0;
    requests_sent = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      table_use[i]  = USE_FREE;
      table_chan[i] = '0;
      table_kind[i] = '0;
      table_age[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) chan_pool[i] = CHAN_W'($urandom);

    // directed: marks on an empty table, extremes, undefined op, kind 3,
    // fill to the last slot, then replacement of the oldest reserved entry
    add_row(OP_MARK_CONN, 16'h0000, 2'd0, 4'd0,  1'b1, 4'd0,  2'd0, OUT_IGNORED);
    add_row(OP_MARK_RSV,  16'h0000, 2'd0, 4'd15, 1'b1, 4'd15, 2'd0, OUT_IGNORED);
    add_row(OP_LOOKUP,    16'h0000, 2'd0, 4'd0,  1'b1, 4'd0,  2'd0, OUT_FREE);
    add_row(OP_LOOKUP,    16'hFFFF, 2'd3, 4'd15, 1'b1, 4'd1,  2'd3, OUT_FREE);
    add_row(OP_LOOKUP,    16'hFFFF, 2'd1, 4'd0,  1'b0, 4'd0,  2'd0, OUT_FOUND);
    add_row(OP_UNDEF,     16'h1234, 2'd2, 4'd3,  1'b0, 4'd0,  2'd0, OUT_FOUND);
    add_row(OP_MARK_CONN, 16'h0000, 2'd0, 4'd1,  1'b0, 4'd0,  2'd0, OUT_FOUND);
    add_row(OP_LOOKUP,    16'h8000, 2'd2, 4'd0,  1'b0, 4'd0,  2'd0, OUT_FOUND);
    for (int k = 0; k < 13; k++)
      add_row(OP_LOOKUP, CHAN_W'(1) << k, KIND_W'(k % 4), 4'd0, 1'b0, 4'd0, 2'd0, OUT_FOUND);
    add_row(OP_LOOKUP,    16'h5555, 2'd1, 4'd0,  1'b0, 4'd0,  2'd0, OUT_FOUND);
    add_row(OP_MARK_RSV,  16'h0000, 2'd0, 4'd1,  1'b0, 4'd0,  2'd0, OUT_FOUND);
    add_row(OP_MARK_CONN, 16'h0000, 2'd0, 4'd15, 1'b0, 4'd0,  2'd0, OUT_FOUND);
    add_row(OP_LOOKUP,    16'hAAAA, 2'd2, 4'd10, 1'b0, 4'd0,  2'd0, OUT_FOUND);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (dir_rows.size() != 0) begin
      row = dir_rows.pop_front();
      drive_request(row.req, row.typed, row.want);
    end

    first = 1'b1;
    while (requests_sent < ITEM_TARGET) begin
      if (requests_sent >= ITEM_TARGET - QUIET_ITEMS) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      // the first episode always drives the table full
      episode = first ? 6 : $urandom_range(0, 9);
      first   = 1'b0;
      if (episode <= 1) begin
        n = $urandom_range(10, 30);
        repeat (n)
          send(make_req(OP_W'($urandom_range(0, 3)), CHAN_W'($urandom), rand_kind(),
                        SLOT_W'($urandom_range(0, 15))));
      end else if (episode <= 5) begin
        n = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: p_conn = 20;
          1: p_conn = 50;
          default: p_conn = 85;
        endcase
        chan_pool[$urandom_range(0, POOL_SIZE - 1)] = CHAN_W'($urandom);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0)
            send(make_req(OP_LOOKUP,
                          ($urandom_range(0, 9) < 7) ? pool_chan() : CHAN_W'($urandom),
                          rand_kind(), SLOT_W'($urandom_range(0, 15))));
          else
            send(make_req(($urandom_range(0, 99) < p_conn) ? OP_MARK_CONN : OP_MARK_RSV,
                          CHAN_W'($urandom), rand_kind(), SLOT_W'($urandom_range(0, 15))));
        end
      end else if (episode <= 7) begin
        // fill, connect every slot, probe, then hand a few slots back
        n = $urandom_range(16, 20);
        repeat (n) begin
          off = $urandom_range(0, POOL_SIZE - 1);
          chan_pool[off] = CHAN_W'($urandom);
          send(make_req(OP_LOOKUP, chan_pool[off], rand_kind(),
                        SLOT_W'($urandom_range(0, 15))));
        end
        off = $urandom_range(0, 15);
        for (int k = 0; k < 16; k++)
          send(make_req(OP_MARK_CONN, CHAN_W'($urandom), rand_kind(),
                        SLOT_W'((off + k) % 16)));
        n = $urandom_range(1, 3);
        repeat (n)
          send(make_req(OP_LOOKUP,
                        ($urandom_range(0, 3) == 0) ? pool_chan() : CHAN_W'($urandom),
                        rand_kind(), SLOT_W'($urandom_range(0, 15))));
        n = $urandom_range(1, 4);
        repeat (n)
          send(make_req(OP_MARK_RSV, CHAN_W'($urandom), rand_kind(),
                        SLOT_W'($urandom_range(0, 15))));
      end else begin
        // miss-heavy run to churn ages among the reserved slots
        n = $urandom_range(10, 30);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0)
            send(make_req(OP_MARK_RSV, CHAN_W'($urandom), rand_kind(),
                          SLOT_W'($urandom_range(0, 15))));
          else
            send(make_req(OP_LOOKUP, CHAN_W'($urandom), rand_kind(),
                          SLOT_W'($urandom_range(0, 15))));
        end
      end
    end

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("channel_table_age_replace_tb passed");
    end else begin
      $display("channel_table_age_replace_tb failed");
    end
    $finish;
  end

endmodule
